// ===== rtl/core/cba_pkg.sv =====
// ----------------------------------------------------------------------------
// cba_pkg
// Shared widths, register indexes and types of the contiguous block allocator.
// ----------------------------------------------------------------------------
package cba_pkg;

  localparam int unsigned SizeW        = 16;
  localparam int unsigned TagW         = 8;
  localparam int unsigned BlockSizeW   = 16;
  localparam int unsigned NumBlocksW   = 8;
  localparam int unsigned CfgDataW     = 16;
  localparam int unsigned CfgIdxW      = 1;
  localparam int unsigned StartW       = 7;
  localparam int unsigned MaxBlocksDef = 128;

  typedef enum logic [CfgIdxW-1:0] {
    CfgBlockSize = 1'b0,
    CfgNumBlocks = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [SizeW-1:0] quotient;
    logic             rem_nz;
  } div_res_t;

endpackage

// ===== rtl/core/cba_ram.sv =====
// ----------------------------------------------------------------------------
// cba_ram
// Generic single-write, single-read memory with a registered read port.
// ----------------------------------------------------------------------------
module cba_ram #(
  parameter int unsigned Width = 1,
  parameter int unsigned Depth = cba_pkg::MaxBlocksDef
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/cba_divider.sv =====
// ----------------------------------------------------------------------------
// cba_divider
// Restoring divider, one quotient bit per cycle, with a remainder-nonzero flag.
// ----------------------------------------------------------------------------
module cba_divider (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [cba_pkg::SizeW-1:0]    dividend_i,
  input  logic [cba_pkg::SizeW-1:0]    divisor_i,
  output logic                         done_o,
  output cba_pkg::div_res_t            res_o
);

  localparam int unsigned W     = cba_pkg::SizeW;
  localparam int unsigned StepW = $clog2(W);

  logic             run_q, run_d;
  logic             done_q, done_d;
  logic [StepW-1:0] step_q, step_d;
  logic [W:0]       rem_q, rem_d;
  logic [W-1:0]     quo_q, quo_d;

  logic [W:0]   shifted;
  logic [W+1:0] diff;
  logic         ge;

  // The caller must hold the divisor steady for the whole division; the divider does not enforce it.
  assign shifted = {rem_q[W-1:0], quo_q[W-1]};
  assign diff    = {1'b0, shifted} - (W+2)'(divisor_i);
  assign ge      = ~diff[W+1];

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    step_d = step_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d  = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
    end else if (run_q) begin
      rem_d  = ge ? diff[W:0] : shifted;
      quo_d  = {quo_q[W-2:0], ge};
      step_d = step_q + StepW'(1);
      if (step_q == StepW'(W-1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign done_o         = done_q;
  assign res_o.quotient = quo_q;
  assign res_o.rem_nz   = |rem_q;

endmodule

// ===== rtl/core/contiguous_block_allocator_top.sv =====
// ----------------------------------------------------------------------------
// contiguous_block_allocator_top
// First-fit allocator of contiguous block runs over a used-block bitmap.
// ----------------------------------------------------------------------------
// After reset the bitmap memory is cleared one entry per cycle, with busy_o
// high; configuration writes are taken during that pass.
// Each word passes through the serial divider and one check, then, if it
// can fit, a bitmap scan and, on a grant, marking writes (none on a refusal)
// before the done_o strobe. A new word is accepted in the cycle of the
// strobe; the receiver cannot stall.
module contiguous_block_allocator_top #(
  parameter int unsigned MaxBlocks = cba_pkg::MaxBlocksDef
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  logic [cba_pkg::SizeW-1:0]       file_size_i,
  input  logic [cba_pkg::TagW-1:0]        file_tag_i,
  input  logic                            cfg_we_i,
  input  logic [cba_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  logic [cba_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output logic                            done_o,
  output logic                            granted_o,
  output logic [cba_pkg::StartW-1:0]      start_block_o,
  output logic [cba_pkg::SizeW-1:0]       block_count_o,
  output logic [cba_pkg::TagW-1:0]        result_tag_o
);

  localparam int unsigned IdxW  = $clog2(MaxBlocks);
  localparam int unsigned LimW  = $clog2(MaxBlocks + 1);
  localparam int unsigned SizeW = cba_pkg::SizeW;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StDiv,
    StCheck,
    StScan,
    StMark
  } state_e;

  state_e                         state_q, state_d;
  logic [IdxW-1:0]                clr_q, clr_d;
  logic [cba_pkg::BlockSizeW-1:0] blk_size_q, blk_size_d;
  logic [cba_pkg::NumBlocksW-1:0] num_blk_q, num_blk_d;
  logic [cba_pkg::TagW-1:0]       tag_q, tag_d;
  logic [SizeW-1:0]               count_q, count_d;
  logic [LimW-1:0]                k_q, k_d;
  logic [LimW-1:0]                run_q, run_d;
  logic                           pend_q, pend_d;
  logic [LimW-1:0]                mk_q, mk_d;
  logic [LimW-1:0]                end_q, end_d;
  logic [LimW-1:0]                st_q, st_d;
  logic                           done_q, done_d;
  logic                           granted_q, granted_d;
  logic [IdxW-1:0]                ostart_q, ostart_d;
  logic [SizeW-1:0]               ocount_q, ocount_d;
  logic [cba_pkg::TagW-1:0]       otag_q, otag_d;

  logic              accept;
  logic [LimW-1:0]   lim;
  logic [LimW-1:0]   run_inc;
  logic              hit;
  logic              div_done;
  cba_pkg::div_res_t div_res;
  logic              ram_we;
  logic [IdxW-1:0]   ram_waddr;
  logic              ram_wdata;
  logic              ram_rdata;

  assign accept = start_i && (state_q == StIdle);

  // A configured block count above the memory depth saturates to the depth.
  assign lim = (16'(num_blk_q) > 16'(MaxBlocks)) ? LimW'(MaxBlocks) : LimW'(num_blk_q);

  assign run_inc = run_q + LimW'(1);
  assign hit     = pend_q && !ram_rdata && (16'(run_inc) == count_q);

  cba_divider u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .dividend_i (file_size_i),
    .divisor_i  (blk_size_q),
    .done_o     (div_done),
    .res_o      (div_res)
  );

  cba_ram #(
    .Width (1),
    .Depth (MaxBlocks)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (k_q[IdxW-1:0]),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = mk_q[IdxW-1:0];
    ram_wdata = 1'b1;
    if (state_q == StClear) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = 1'b0;
    end else if (state_q == StMark) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    blk_size_d = blk_size_q;
    num_blk_d  = num_blk_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        cba_pkg::CfgBlockSize: blk_size_d = cfg_wdata_i;
        cba_pkg::CfgNumBlocks: num_blk_d  = cfg_wdata_i[cba_pkg::NumBlocksW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    tag_d     = tag_q;
    count_d   = count_q;
    k_d       = k_q;
    run_d     = run_q;
    pend_d    = pend_q;
    mk_d      = mk_q;
    end_d     = end_q;
    st_d      = st_q;
    done_d    = 1'b0;
    granted_d = granted_q;
    ostart_d  = ostart_q;
    ocount_d  = ocount_q;
    otag_d    = otag_q;
    unique case (state_q)
      StClear: begin
        clr_d = clr_q + IdxW'(1);
        if (clr_q == IdxW'(MaxBlocks - 1)) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        if (accept) begin
          tag_d   = file_tag_i;
          state_d = StDiv;
        end
      end
      StDiv: begin
        if (div_done) begin
          // A zero block size cannot divide and yields a zero count.
          count_d = (blk_size_q == '0) ? '0
                  : div_res.quotient + SizeW'(div_res.rem_nz);
          state_d = StCheck;
        end
      end
      StCheck: begin
        k_d    = '0;
        run_d  = '0;
        pend_d = 1'b0;
        if ((count_q == '0) || (count_q > 16'(lim))) begin
          done_d    = 1'b1;
          granted_d = 1'b0;
          ostart_d  = '0;
          ocount_d  = count_q;
          otag_d    = tag_q;
          state_d   = StIdle;
        end else begin
          state_d = StScan;
        end
      end
      StScan: begin
        // Read data in this cycle belongs to block k_q-1.
        if (pend_q) begin
          run_d = ram_rdata ? '0 : run_inc;
        end
        if (hit) begin
          pend_d  = 1'b0;
          end_d   = k_q;
          st_d    = k_q - LimW'(count_q);
          mk_d    = k_q - LimW'(count_q);
          state_d = StMark;
        end else if (k_q == lim) begin
          pend_d    = 1'b0;
          done_d    = 1'b1;
          granted_d = 1'b0;
          ostart_d  = '0;
          ocount_d  = count_q;
          otag_d    = tag_q;
          state_d   = StIdle;
        end else begin
          pend_d = 1'b1;
          k_d    = k_q + LimW'(1);
        end
      end
      StMark: begin
        mk_d = mk_q + LimW'(1);
        if ((mk_q + LimW'(1)) == end_q) begin
          done_d    = 1'b1;
          granted_d = 1'b1;
          ostart_d  = st_q[IdxW-1:0];
          ocount_d  = count_q;
          otag_d    = tag_q;
          state_d   = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StClear;
      clr_q      <= '0;
      blk_size_q <= cba_pkg::BlockSizeW'(1);
      num_blk_q  <= cba_pkg::NumBlocksW'(128);
      pend_q     <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      blk_size_q <= blk_size_d;
      num_blk_q  <= num_blk_d;
      pend_q     <= pend_d;
      done_q     <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q     <= tag_d;
    count_q   <= count_d;
    k_q       <= k_d;
    run_q     <= run_d;
    mk_q      <= mk_d;
    end_q     <= end_d;
    st_q      <= st_d;
    granted_q <= granted_d;
    ostart_q  <= ostart_d;
    ocount_q  <= ocount_d;
    otag_q    <= otag_d;
  end

  assign busy_o        = (state_q != StIdle);
  assign done_o        = done_q;
  assign granted_o     = granted_q;
  assign start_block_o = cba_pkg::StartW'(ostart_q);
  assign block_count_o = ocount_q;
  assign result_tag_o  = otag_q;

  // A strobe only ever ends a busy stretch.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_o))
    else $error("result strobe without a preceding busy cycle");

  // An accepted word keeps the block busy in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> busy_o)
    else $error("block not busy after accepting a word");

  // A granted run is nonempty and lies inside the blocks in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_q && granted_q) |->
      ((ocount_q != '0) && ((17'(ostart_q) + 17'(ocount_q)) <= 17'(lim))))
    else $error("granted run is empty or exceeds the block limit");

  // The marking pass never walks past the end of the found run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StMark) |-> (mk_q < end_q))
    else $error("marking address past end of run");

endmodule
